>>> rtl/core/c_string_literal_escaper_unit_macros.svh
// assertion macros for the string literal escaper checker
`ifndef C_STRING_LITERAL_ESCAPER_UNIT_MACROS_SVH
`define C_STRING_LITERAL_ESCAPER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ESC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/esc_pkg.sv
// shared types and constants of the string literal escaper
package esc_pkg;

    localparam int CHAR_W       = 8;
    localparam int LW_W         = 12;
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 2;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [PADDR_W-1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [LW_W-1:0]    LINE_WIDTH_RESET = 12'd80;

    // output character slots of one request, emitted in this order
    localparam int STEP_N     = 10;
    localparam int STEP_OPEN  = 0;
    localparam int STEP_WRAP0 = 1;
    localparam int STEP_WRAP1 = 2;
    localparam int STEP_WRAP2 = 3;
    localparam int STEP_P0    = 4;
    localparam int STEP_P1    = 5;
    localparam int STEP_P2    = 6;
    localparam int STEP_P3    = 7;
    localparam int STEP_CLOSE = 8;
    localparam int STEP_NL    = 9;

    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'd34;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'd92;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_X     = 8'd120;

    typedef logic [$clog2(STEP_N)-1:0] step_t;

    typedef struct packed {
        logic [STEP_N-1:0] mask;
        logic [CHAR_W-1:0] data;
        logic              esc;
        logic              hx;
    } job_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] ch;
        if (nib < 4'd10)
        begin
            ch = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            ch = 8'd87 + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

>>> rtl/core/esc_front.sv
// front end: classifies each byte, decides wrapping and builds a character job
module esc_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [esc_pkg::CHAR_W-1:0] data_byte,
    input  logic                       last_byte,
    input  logic [esc_pkg::LW_W-1:0]   line_width,
    output esc_pkg::job_t              job
);
    import esc_pkg::*;

    logic            prev_esc_reg, prev_esc_next;
    logic            opened_reg, opened_next;
    logic [LW_W-1:0] col_reg, col_next;

    logic       printable, is_hex, lit, zero, hx, wrap;
    logic [2:0] plen;

    always_comb
    begin
        printable = (data_byte >= 8'd32) && (data_byte <= 8'd126) &&
                    (data_byte != CH_QUOTE) && (data_byte != CH_BSLASH);
        is_hex = ((data_byte >= 8'd48) && (data_byte <= 8'd57)) ||
                 ((data_byte >= 8'd65) && (data_byte <= 8'd70)) ||
                 ((data_byte >= 8'd97) && (data_byte <= 8'd102));
        lit  = printable && (!prev_esc_reg || !is_hex);
        zero = !lit && (data_byte == 8'd0);
        hx   = !lit && !zero;
        plen = lit ? 3'd1 : (zero ? 3'd2 : 3'd4);
        // signed compare against width minus the two quotes
        wrap = ($signed({2'b00, col_reg}) + $signed({11'd0, plen})) >
               ($signed({2'b00, line_width}) - 14'sd2);

        job.mask = '0;
        job.mask[STEP_OPEN]  = !opened_reg;
        job.mask[STEP_WRAP0] = wrap;
        job.mask[STEP_WRAP1] = wrap;
        job.mask[STEP_WRAP2] = wrap;
        job.mask[STEP_P0]    = 1'b1;
        job.mask[STEP_P1]    = !lit;
        job.mask[STEP_P2]    = hx;
        job.mask[STEP_P3]    = hx;
        job.mask[STEP_CLOSE] = last_byte;
        job.mask[STEP_NL]    = last_byte;
        job.data = data_byte;
        job.esc  = !lit;
        job.hx   = hx;

        if (last_byte)
        begin
            col_next      = '0;
            prev_esc_next = 1'b0;
            opened_next   = 1'b0;
        end
        else
        begin
            col_next      = wrap ? {9'd0, plen} : col_reg + {9'd0, plen};
            prev_esc_next = !lit;
            opened_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_esc_reg <= 1'b0;
            opened_reg   <= 1'b0;
            col_reg      <= '0;
        end
        else if (take)
        begin
            prev_esc_reg <= prev_esc_next;
            opened_reg   <= opened_next;
            col_reg      <= col_next;
        end
    end

endmodule

>>> rtl/core/esc_fifo.sv
// small job queue between the front end and the character sequencer
module esc_fifo
#(
    parameter int DEPTH = esc_pkg::FIFO_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  esc_pkg::job_t wr_job,
    input  logic          rd,
    output esc_pkg::job_t rd_job,
    output logic          full,
    output logic          empty
);
    import esc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_job = entry_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/esc_back.sv
// back end: walks the slots of each job and emits one character per cycle while its output is empty or popped
module esc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  esc_pkg::job_t              head_job,
    input  logic                       head_valid,
    output logic                       head_take,
    output logic                       empty,
    input  logic                       pop,
    output logic [esc_pkg::CHAR_W-1:0] out_char,
    output logic                       run_last
);
    import esc_pkg::*;

    logic [STEP_N-1:0] mask_reg, mask_next;
    logic [CHAR_W-1:0] data_reg;
    logic              esc_reg, hx_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    logic              can_emit, emit, use_head;
    logic [STEP_N-1:0] eff_mask;
    logic [CHAR_W-1:0] eff_data;
    logic              eff_esc, eff_hx;
    step_t             step;
    logic [CHAR_W-1:0] ch;

    assign can_emit = !out_valid_reg || pop;
    assign use_head = (mask_reg == '0) && head_valid;
    assign emit     = can_emit && ((mask_reg != '0) || head_valid);
    assign head_take = can_emit && use_head;

    always_comb
    begin
        eff_mask = use_head ? head_job.mask : mask_reg;
        eff_data = use_head ? head_job.data : data_reg;
        eff_esc  = use_head ? head_job.esc  : esc_reg;
        eff_hx   = use_head ? head_job.hx   : hx_reg;

        // lowest pending slot
        step = '0;
        for (int i = STEP_N - 1; i >= 0; i--)
        begin
            if (eff_mask[i])
            begin
                step = step_t'(i);
            end
        end
        mask_next = eff_mask;
        mask_next[step] = 1'b0;

        unique case (int'(step))
            STEP_OPEN, STEP_WRAP0, STEP_WRAP2, STEP_CLOSE: ch = CH_QUOTE;
            STEP_WRAP1, STEP_NL:                           ch = CH_NL;
            STEP_P0: ch = eff_esc ? CH_BSLASH : eff_data;
            STEP_P1: ch = eff_hx ? CH_X : CH_ZERO;
            STEP_P2: ch = hex_char(eff_data[7:4]);
            STEP_P3: ch = hex_char(eff_data[3:0]);
            default: ch = CH_QUOTE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= ch;
            last_reg <= (mask_next == '0);
        end
        if (head_take)
        begin
            data_reg <= head_job.data;
            esc_reg  <= head_job.esc;
            hx_reg   <= head_job.hx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                mask_reg      <= mask_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty    = !out_valid_reg;
    assign out_char = char_reg;
    assign run_last = last_reg;

endmodule

>>> rtl/core/c_string_literal_escaper_unit.sv
// top level of the string literal escaper
// Turns raw bytes into the characters of a quoted C string literal, one
// character per pop. A plain printable byte gives one character, a zero byte
// two, any other byte four; the opening quote, a line wrap (quote, newline,
// quote) and the closing quote plus newline after a byte marked last add to
// that, so one byte yields 1 to 10 characters. The character sequencer emits
// one character per clock while its result is empty or being popped, so a
// byte occupies it until all the characters it yields are emitted, and
// throughput is one character per cycle while pop keeps up. A job queue of
// FIFO_DEPTH entries lets the classifier keep accepting bytes, one per cycle
// while the queue is not full, while the sequencer is busy; an accepted
// push's job is queued and its first character then registered for output.
// The line width register sits at address 0 of the APB port, reset 80.
module c_string_literal_escaper_unit
#(
    parameter int FIFO_DEPTH = esc_pkg::FIFO_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [esc_pkg::CHAR_W-1:0]  data_byte,
    input  logic                        last_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [esc_pkg::CHAR_W-1:0]  out_char,
    output logic                        run_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esc_pkg::PADDR_W-1:0] paddr,
    input  logic [esc_pkg::DATA_W-1:0]  pwdata,
    output logic [esc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import esc_pkg::*;

    logic [LW_W-1:0] line_width_reg;
    logic            take;
    job_t            new_job, head_job;
    logic            q_empty, head_take;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LINE_WIDTH) ?
                    {{(DATA_W - LW_W){1'b0}}, line_width_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_LINE_WIDTH))
        begin
            line_width_reg <= pwdata[LW_W-1:0];
        end
    end

    assign take = push && !full;

    esc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .line_width (line_width_reg),
        .job        (new_job)
    );

    esc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (take),
        .wr_job (new_job),
        .rd     (head_take),
        .rd_job (head_job),
        .full   (full),
        .empty  (q_empty)
    );

    esc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_valid (!q_empty),
        .head_take  (head_take),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .run_last   (run_last)
    );

endmodule

>>> rtl/core/esc_checker.sv
// port-level checker for the string literal escaper, bound to the top level
`include "c_string_literal_escaper_unit_macros.svh"

module esc_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic [esc_pkg::CHAR_W-1:0] out_char,
    input logic                       run_last,
    input logic                       pready
);
    import esc_pkg::*;

    // a waiting character stays put until it is popped
    `ESC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_char) && $stable(run_last), "result changed while stalled")

    // a request never ends on a quote: the piece or the newline comes last
    `ESC_ASSERT_NOW(a_last_not_quote, !empty && run_last, out_char != CH_QUOTE, "request ended on a quote")

    // a backslash always has its escape characters after it
    `ESC_ASSERT_NOW(a_bslash_not_last, !empty && (out_char == CH_BSLASH), !run_last, "request ended on a backslash")

    `ESC_ASSERT_NOW(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind c_string_literal_escaper_unit esc_checker u_esc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .run_last (run_last),
    .pready   (pready)
);
